### hdl/wmps_pkg.sv
// ----------------------------------------------------------------------------
// wmps_pkg
// Widths and limits shared by the windowed max-product selection core and
// its checker.
// ----------------------------------------------------------------------------
package wmps_pkg;

    localparam int VALUE_W    = 7;   // element width, signed
    localparam int PROD_W     = 62;  // product / row entry width, signed
    localparam int PICK_W     = 4;   // pick count register width
    localparam int GAP_W      = 7;   // max gap register width
    localparam int PICK_LIMIT = 10;  // largest pick count honored
    localparam int DATA_W     = 32;  // configuration data width
    localparam int ADDR_W     = 3;   // configuration byte address width

    // Register indexes on the configuration port (word address)
    localparam logic REG_PICK_COUNT = 1'b0;
    localparam logic REG_MAX_GAP    = 1'b1;

    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [VALUE_W-1:0] value_t;

endpackage

### hdl/wmps_ram.sv
// ----------------------------------------------------------------------------
// wmps_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module wmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/windowed_max_product_selection_core.sv
// ----------------------------------------------------------------------------
// windowed_max_product_selection_core
// Loads a signed sequence and finds the greatest product of k elements picked
// in order, with neighboring picks at most d positions apart.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: a request (value, last) is taken at a rising edge where
//   start is high and busy is low. While loading, one request is taken per
//   cycle and busy stays low. Each element that fits is written into the element
//   store and into both product rows (layer one of the search).
//   The request with last high closes the set. If fewer elements were loaded
//   than the clamped pick count, the result (valid_res=0, best_product=0) appears
//   on the next cycle. Otherwise busy rises and the layered search runs on
//   one shared 7x62 multiplier and one max/min compare pair:
//     per layer, per end position p: the window from lo = max(p - d, layer - 2)
//     to p - 1 is scanned for its max and min, which the element multiplies into
//     both rows at p; then a final scan for the maximum over the top row.
//   The row memories have one read port, so the window scan reads one entry
//   per cycle.
//   Result channel: done is high for exactly one cycle with best_product and
//   valid_res; the receiver cannot stall it. busy falls in that same cycle.
//   Configuration: APB write of pick_count (0x0) and max_gap (0x4); write
//   only while idle. pready is tied high; reads return the register.
//   Reset: asynchronous, active low; clears the element count, sequencer and
//   strobe, and sets pick_count and max_gap to 1. Memories are not cleared.
// ----------------------------------------------------------------------------
module windowed_max_product_selection_core #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            start,
    output logic                            busy,
    input  logic signed [wmps_pkg::VALUE_W-1:0] value,
    input  logic                            last,
    // result channel
    output logic                            done,
    output logic signed [wmps_pkg::PROD_W-1:0] best_product,
    output logic                            valid_res,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wmps_pkg::ADDR_W-1:0]     paddr,
    input  logic [wmps_pkg::DATA_W-1:0]     pwdata,
    output logic [wmps_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    import wmps_pkg::*;

    localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int SW    = IDX_W + 9;   // signed width for window bounds
    localparam int CW    = CNT_W + PICK_W;
    localparam int UW    = IDX_W + PICK_W;
    localparam int MUL_W = PROD_W + VALUE_W;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PSTART = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_DRAIN  = 4'd3;
    localparam logic [3:0] S_MULH   = 4'd4;
    localparam logic [3:0] S_MULL   = 4'd5;
    localparam logic [3:0] S_WRL    = 4'd6;
    localparam logic [3:0] S_FSCAN  = 4'd7;
    localparam logic [3:0] S_FDRAIN = 4'd8;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PICK_W-1:0] pick_count_reg;
    logic [GAP_W-1:0]  max_gap_reg;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pick_count_reg <= PICK_W'(1);
            max_gap_reg    <= GAP_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_PICK_COUNT: pick_count_reg <= pwdata[PICK_W-1:0];
                REG_MAX_GAP:    max_gap_reg    <= pwdata[GAP_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_PICK_COUNT: prdata = DATA_W'(pick_count_reg);
            REG_MAX_GAP:    prdata = DATA_W'(max_gap_reg);
            default:        prdata = '0;
        endcase
    end

    // Clamp k into 1..PICK_LIMIT and d to at least 1
    logic [PICK_W-1:0] k_eff;
    logic [GAP_W-1:0]  d_eff;

    always_comb
    begin
        if (pick_count_reg == '0)
            k_eff = PICK_W'(1);
        else if (pick_count_reg > PICK_W'(PICK_LIMIT))
            k_eff = PICK_W'(PICK_LIMIT);
        else
            k_eff = pick_count_reg;
        d_eff = (max_gap_reg == '0) ? GAP_W'(1) : max_gap_reg;
    end

    // ------------------------------------------------------------------
    // Sequencer registers
    // ------------------------------------------------------------------
    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  nm1_reg, nm1_next;      // last element index
    logic [IDX_W-1:0]  p_reg, p_next;          // end position
    logic [IDX_W-1:0]  q_reg, q_next;          // scan position
    logic [PICK_W-1:0] layer_reg, layer_next;
    logic              first_reg, first_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              done_reg, done_next;
    prod_t             acc_hi_reg, acc_hi_next;
    prod_t             acc_lo_reg, acc_lo_next;
    prod_t             prod_reg, prod_next;
    prod_t             best_reg, best_next;
    logic              valid_reg, valid_next;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic               elem_we;
    logic [IDX_W-1:0]   elem_waddr;
    logic [VALUE_W-1:0] elem_rdata;
    logic               hi_we, lo_we;
    logic [IDX_W-1:0]   row_waddr;
    prod_t              hi_wdata, lo_wdata;
    logic [PROD_W-1:0]  hi_rdata, lo_rdata;

    wmps_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_elem_ram (
        .clk   (clk),
        .we    (elem_we),
        .waddr (elem_waddr),
        .wdata (value),
        .raddr (p_reg),
        .rdata (elem_rdata)
    );

    wmps_ram #(
        .WIDTH (PROD_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_hi_ram (
        .clk   (clk),
        .we    (hi_we),
        .waddr (row_waddr),
        .wdata (hi_wdata),
        .raddr (q_reg),
        .rdata (hi_rdata)
    );

    wmps_ram #(
        .WIDTH (PROD_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_lo_ram (
        .clk   (clk),
        .we    (lo_we),
        .waddr (row_waddr),
        .wdata (lo_wdata),
        .raddr (q_reg),
        .rdata (lo_rdata)
    );

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic              accept;
    logic              room;
    logic [CNT_W-1:0]  n_load;
    logic [CNT_W-1:0]  n_load_m1;
    logic signed [SW-1:0] p_minus_d, floor_pos, lo_pos;
    value_t            v;
    prod_t             mul_op;
    logic signed [MUL_W-1:0] mul_full;
    prod_t             rd_hi, rd_lo;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start & ~busy;
    assign room      = (count_reg < CNT_W'(MAX_ELEMENTS));
    assign n_load    = room ? (count_reg + CNT_W'(1)) : count_reg;
    assign n_load_m1 = n_load - CNT_W'(1);

    // Window start: lo = max(p - d, layer - 2)
    assign p_minus_d = $signed(SW'(p_reg)) - $signed(SW'(d_eff));
    assign floor_pos = $signed(SW'(layer_reg)) - $signed(SW'(2));
    assign lo_pos    = (p_minus_d < floor_pos) ? floor_pos : p_minus_d;

    assign v     = $signed(elem_rdata);
    assign rd_hi = $signed(hi_rdata);
    assign rd_lo = $signed(lo_rdata);

    // Shared multiplier: a negative element swaps the roles of max and min
    always_comb
    begin
        if (state_reg == S_MULH)
            mul_op = (v < 0) ? acc_lo_reg : acc_hi_reg;
        else
            mul_op = (v < 0) ? acc_hi_reg : acc_lo_reg;
    end

    assign mul_full = MUL_W'(v) * MUL_W'(mul_op);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        nm1_next      = nm1_reg;
        p_next        = p_reg;
        q_next        = q_reg;
        layer_next    = layer_reg;
        first_next    = first_reg;
        rd_valid_next = 1'b0;
        done_next     = 1'b0;
        acc_hi_next   = acc_hi_reg;
        acc_lo_next   = acc_lo_reg;
        prod_next     = prod_reg;
        best_next     = best_reg;
        valid_next    = valid_reg;

        elem_we    = 1'b0;
        elem_waddr = count_reg[IDX_W-1:0];
        hi_we      = 1'b0;
        lo_we      = 1'b0;
        row_waddr  = p_reg;
        hi_wdata   = prod_reg;
        lo_wdata   = prod_reg;

        // Fold in the row entry read last cycle
        if (rd_valid_reg)
        begin
            first_next = 1'b0;
            if (first_reg)
            begin
                acc_hi_next = rd_hi;
                acc_lo_next = rd_lo;
            end
            else
            begin
                acc_hi_next = (rd_hi > acc_hi_reg) ? rd_hi : acc_hi_reg;
                acc_lo_next = (rd_lo < acc_lo_reg) ? rd_lo : acc_lo_reg;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // Store the element and seed both rows with layer one
                    if (room)
                    begin
                        elem_we   = 1'b1;
                        hi_we     = 1'b1;
                        lo_we     = 1'b1;
                        row_waddr = count_reg[IDX_W-1:0];
                        hi_wdata  = PROD_W'(value);
                        lo_wdata  = PROD_W'(value);
                    end
                    count_next = n_load;
                    if (last)
                    begin
                        count_next = '0;
                        nm1_next   = n_load_m1[IDX_W-1:0];
                        if (CW'(n_load) < CW'(k_eff))
                        begin
                            // Short set: report at once
                            done_next  = 1'b1;
                            best_next  = '0;
                            valid_next = 1'b0;
                        end
                        else if (k_eff == PICK_W'(1))
                        begin
                            q_next     = IDX_W'(k_eff - PICK_W'(1));
                            first_next = 1'b1;
                            state_next = S_FSCAN;
                        end
                        else
                        begin
                            layer_next = PICK_W'(2);
                            p_next     = n_load_m1[IDX_W-1:0];
                            state_next = S_PSTART;
                        end
                    end
                end
            end

            S_PSTART:
            begin
                q_next     = lo_pos[IDX_W-1:0];
                first_next = 1'b1;
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                rd_valid_next = 1'b1;
                if (q_reg == p_reg - IDX_W'(1))
                    state_next = S_DRAIN;
                else
                    q_next = q_reg + IDX_W'(1);
            end

            S_DRAIN:
            begin
                state_next = S_MULH;
            end

            S_MULH:
            begin
                prod_next  = mul_full[PROD_W-1:0];
                state_next = S_MULL;
            end

            S_MULL:
            begin
                hi_we      = 1'b1;
                prod_next  = mul_full[PROD_W-1:0];
                state_next = S_WRL;
            end

            S_WRL:
            begin
                lo_we = 1'b1;
                if (UW'(p_reg) == UW'(layer_reg - PICK_W'(1)))
                begin
                    if (layer_reg == k_eff)
                    begin
                        q_next     = IDX_W'(k_eff - PICK_W'(1));
                        first_next = 1'b1;
                        state_next = S_FSCAN;
                    end
                    else
                    begin
                        layer_next = layer_reg + PICK_W'(1);
                        p_next     = nm1_reg;
                        state_next = S_PSTART;
                    end
                end
                else
                begin
                    p_next     = p_reg - IDX_W'(1);
                    state_next = S_PSTART;
                end
            end

            S_FSCAN:
            begin
                rd_valid_next = 1'b1;
                if (q_reg == nm1_reg)
                    state_next = S_FDRAIN;
                else
                    q_next = q_reg + IDX_W'(1);
            end

            S_FDRAIN:
            begin
                // Last top-row entry folds in this cycle; report next
                done_next  = 1'b1;
                best_next  = acc_hi_next;
                valid_next = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            first_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_valid_reg <= rd_valid_next;
            done_reg     <= done_next;
            first_reg    <= first_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        nm1_reg    <= nm1_next;
        p_reg      <= p_next;
        q_reg      <= q_next;
        layer_reg  <= layer_next;
        acc_hi_reg <= acc_hi_next;
        acc_lo_reg <= acc_lo_next;
        prod_reg   <= prod_next;
        best_reg   <= best_next;
        valid_reg  <= valid_next;
    end

    assign done         = done_reg;
    assign best_product = best_reg;
    assign valid_res    = valid_reg;

endmodule

### hdl/wmps_checker.sv
// ----------------------------------------------------------------------------
// wmps_checker
// Port-level checks for the windowed max-product selection core.
// ----------------------------------------------------------------------------
module wmps_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            last,
    input logic                            done,
    input logic                            valid_res,
    input logic signed [wmps_pkg::PROD_W-1:0] best_product
);

    import wmps_pkg::*;

    // A request that does not close the set gives no result
    a_no_result_mid_set: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy && !last) |=> !done
    ) else $error("result strobe after a request that did not close the set");

    // A closing request either reports at once or starts the search
    a_close_reacts: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy && last) |=> (busy || done)
    ) else $error("closing request neither reported nor started the search");

    // The block is idle whenever it reports
    a_idle_on_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> !busy
    ) else $error("result strobe while busy");

    // A short set reports a zero product
    a_short_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && !valid_res) |-> (best_product == '0)
    ) else $error("short set reported a nonzero product");

endmodule

bind windowed_max_product_selection_core wmps_checker u_wmps_checker (.*);

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb - windowed max-product selection core checker
// Drives sets of signed elements into the core through start/busy, writes
// pick_count and max_gap over the APB port between sets, and checks every
// done strobe against an in-bench model of the layered max/min search.
// ----------------------------------------------------------------------------
module tb;

    import wmps_pkg::*;

    localparam int MAX_ELEMENTS = 64;
    localparam logic [ADDR_W-1:0] ADDR_PICK = {REG_PICK_COUNT, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_GAP  = {REG_MAX_GAP, 2'b00};
    localparam int PHASES     = 10;
    localparam int PHASE_REQS = 55;

    // Result expected for one closed set
    typedef struct {
        logic [PROD_W-1:0] best;
        logic              ok;
    } product_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the element store and registers, predicts one
    // result per closing request and matches it against the done strobe.
    // ------------------------------------------------------------------------
    class max_product_board;
        int          errors;
        int unsigned picks;
        int unsigned gap;
        int unsigned n_loaded;
        longint      elems[MAX_ELEMENTS];
        product_t    pending_products[$];

        function new();
            errors   = 0;
            picks    = 1;
            gap      = 1;
            n_loaded = 0;
        endfunction

        function void set_pick(int unsigned x);
            picks = x & ((1 << PICK_W) - 1);
        endfunction

        function void set_gap(int unsigned x);
            gap = x & ((1 << GAP_W) - 1);
        endfunction

        function int pending();
            return pending_products.size();
        endfunction

        // Layered search over the loaded elements
        function product_t best_window_product();
            longint   hi_row[MAX_ELEMENTS];
            longint   lo_row[MAX_ELEMENTS];
            longint   v, hi, lw, top;
            int       k, d, n, lyr, p, q, lo;
            product_t res;
            n = n_loaded;
            k = picks;
            d = gap;
            if (k < 1) k = 1;
            if (k > PICK_LIMIT) k = PICK_LIMIT;
            if (d < 1) d = 1;
            res.best = '0;
            res.ok   = 1'b0;
            if (n < k)
                return res;
            for (p = 0; p < n; p++)
            begin
                hi_row[p] = elems[p];
                lo_row[p] = elems[p];
            end
            for (lyr = 2; lyr <= k; lyr++)
            begin
                // walk end positions downward so lower entries keep the old layer
                for (p = n - 1; p >= lyr - 1; p--)
                begin
                    v  = elems[p];
                    lo = p - d;
                    if (lo < lyr - 2) lo = lyr - 2;
                    hi = hi_row[lo];
                    lw = lo_row[lo];
                    for (q = lo + 1; q <= p - 1; q++)
                    begin
                        if (hi_row[q] > hi) hi = hi_row[q];
                        if (lo_row[q] < lw) lw = lo_row[q];
                    end
                    if (v > 0)
                    begin
                        hi_row[p] = v * hi;
                        lo_row[p] = v * lw;
                    end
                    else if (v < 0)
                    begin
                        hi_row[p] = v * lw;
                        lo_row[p] = v * hi;
                    end
                    else
                    begin
                        hi_row[p] = 0;
                        lo_row[p] = 0;
                    end
                end
            end
            top = hi_row[k - 1];
            for (p = k; p < n; p++)
                if (hi_row[p] > top) top = hi_row[p];
            res.best = top[PROD_W-1:0];
            res.ok   = 1'b1;
            return res;
        endfunction

        function void note_request(value_t v, logic l);
            if (n_loaded < MAX_ELEMENTS)
            begin
                elems[n_loaded] = longint'(v);
                n_loaded++;
            end
            if (l)
            begin
                pending_products.push_back(best_window_product());
                n_loaded = 0;
            end
        endfunction

        function void check_result(logic [PROD_W-1:0] best, logic ok);
            product_t want;
            if (pending_products.size() == 0)
            begin
                $error("unexpected result: best_product=%0d valid_res=%0b",
                       $signed(best), ok);
                errors++;
                return;
            end
            want = pending_products.pop_front();
            if (best !== want.best)
            begin
                $error("best_product: expected %0d, actual %0d",
                       $signed(want.best), $signed(best));
                errors++;
            end
            if (ok !== want.ok)
            begin
                $error("valid_res: expected %0b, actual %0b", want.ok, ok);
                errors++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    value_t               value;
    logic                 last;
    logic                 done;
    prod_t                best_product;
    logic                 valid_res;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    max_product_board board = new();
    int burst_left = 0;

    windowed_max_product_selection_core #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .value       (value),
        .last        (last),
        .done        (done),
        .best_product(best_product),
        .valid_res   (valid_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #10 clk = ~clk;

    // Monitor at the rising edge. Check first: a done strobe always belongs
    // to a set closed earlier than any request taken on the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                board.check_result(best_product, valid_res);
            if (start && !busy)
                board.note_request(value, last);
        end
    end

    // Hold one request until the core takes it
    task automatic send(value_t v, logic l);
        @(negedge clk);
        start = 1'b1;
        value = v;
        last  = l;
        do @(posedge clk); while (busy);
    endtask

    // Drop start and scramble value; n sets the length of the pause
    task automatic pause(int n);
        @(negedge clk);
        start = 1'b0;
        value = value_t'($urandom);
        repeat (n - 1) @(negedge clk);
    endtask

    // Send in bursts; between bursts idle for a random gap, or not at all
    task automatic offer(value_t v, logic l);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 8));
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        send(v, l);
    endtask

    // Hold off until every predicted result has come, then let the core rest
    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        last  = 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // APB write of one register followed by a read-back check
    task automatic write_reg(logic [ADDR_W-1:0] addr, int unsigned data);
        logic [DATA_W-1:0] want;
        if (addr == ADDR_PICK)
            want = data & ((1 << PICK_W) - 1);
        else
            want = data & ((1 << GAP_W) - 1);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == ADDR_PICK)
            board.set_pick(data);
        else
            board.set_gap(data);
        // read back
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
        begin
            $error("prdata at 0x%0h: expected %0d, actual %0d", addr, want, prdata);
            board.errors++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic configure(int unsigned k, int unsigned d);
        write_reg(ADDR_PICK, k);
        write_reg(ADDR_GAP, d);
    endtask

    // Mix wide-range values with small ones (zeros, sign flips) and extremes
    function automatic value_t random_value();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel < 12)
            return value_t'($urandom);
        else if (sel < 17)
            return value_t'($signed($urandom_range(0, 4)) - 2);
        else
        begin
            case ($urandom_range(0, 3))
                0: return value_t'(-64);
                1: return value_t'(63);
                2: return value_t'(-1);
                default: return value_t'(1);
            endcase
        end
    endfunction

    // Send one whole set; mostly short, sometimes past the store size
    task automatic run_set(logic force_long, inout int sent);
        int len, i, sel;
        sel = $urandom_range(0, 19);
        if (force_long || sel == 0)
            len = $urandom_range(MAX_ELEMENTS, MAX_ELEMENTS + 8);
        else if (sel < 3)
            len = $urandom_range(13, 40);
        else
            len = $urandom_range(1, 12);
        for (i = 0; i < len; i++)
            offer(random_value(), i == len - 1);
        sent += len;
    endtask

    initial
    begin
        int ph, k, d, sent;
        rst_n   = 1'b0;
        start   = 1'b0;
        value   = '0;
        last    = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (4) @(posedge clk);

        // Reset settings: single pick, both extremes and a zero
        send(value_t'(-64), 1'b0);
        send(value_t'(63), 1'b0);
        send(value_t'(0), 1'b1);
        send(value_t'(0), 1'b1);
        settle();

        // Two picks, adjacent only; then a set shorter than the pick count
        configure(2, 1);
        send(value_t'(-64), 1'b0);
        send(value_t'(-64), 1'b0);
        send(value_t'(5), 1'b1);
        send(value_t'(7), 1'b1);
        settle();

        // Zero pick count and zero gap both act as one
        configure(0, 0);
        send(value_t'(-3), 1'b0);
        send(value_t'(0), 1'b0);
        send(value_t'(-5), 1'b1);
        settle();

        // Pick count saturates at ten, gap wider than any set
        configure(15, 127);
        repeat (9) send(value_t'(-64), 1'b0);
        send(value_t'(-64), 1'b1);
        send(value_t'(63), 1'b1);
        settle();

        // Random phases, each under its own register setting
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: begin k = PICK_LIMIT; d = MAX_ELEMENTS; end
                1: begin k = 1;  d = 1;   end
                2: begin k = 15; d = 127; end
                3: begin k = 0;  d = 0;   end
                4: begin k = PICK_LIMIT; d = 1; end
                default:
                begin
                    k = $urandom_range(0, 15);
                    d = $urandom_range(0, 127);
                end
            endcase
            configure(k, d);
            sent = 0;
            while (sent < PHASE_REQS)
                run_set(ph == 1 && sent == 0, sent);
            settle();
        end

        repeat (50) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("** windowed_max_product_selection_core: PASSED **");
        else
            $display("** windowed_max_product_selection_core: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #100_000_000;
        $display("** windowed_max_product_selection_core: FAILED **");
        $finish;
    end

endmodule

### filelist.f
hdl/wmps_pkg.sv
hdl/wmps_ram.sv
hdl/windowed_max_product_selection_core.sv
hdl/wmps_checker.sv
bench/tb.sv
